// ===== rtl/dd_odo_pkg.sv =====
`timescale 1ns / 1ps
package dd_odo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned TAB_LEN          = 24;
  localparam int unsigned TAB_IDX_W        = 5;

  localparam int unsigned MUL_W  = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned DIV_W  = 72;
  localparam int unsigned DVS_W  = 32;

  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [15:0]        RADIUS_RST = 16'd2163;
  localparam logic [15:0]        SEP_RST    = 16'd11141;
  localparam logic signed [19:0] PI_Q       = 20'sd205887;
  localparam logic signed [19:0] TWO_PI_Q   = 20'sd411775;
  localparam logic signed [31:0] CORDIC_K   = 32'sd652032874;
  localparam logic [19:0]        US_PER_S   = 20'd1000000;

  // floor(2^51 / TWO_PI_Q), reciprocal for the heading remainder
  localparam logic signed [MUL_W-1:0] TWO_PI_RECIP = 34'sd5468519977;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 1'b0,
    REG_SEP    = 1'b1
  } cfg_reg_e;

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // arctan(2^-i) in Q2.30
  function automatic logic [29:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd843314856;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043836;
      5'd3:  v = 30'd133525158;
      5'd4:  v = 30'd67021686;
      5'd5:  v = 30'd33543515;
      5'd6:  v = 30'd16775850;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194282;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048575;
      5'd11: v = 30'd524287;
      5'd12: v = 30'd262143;
      5'd13: v = 30'd131071;
      5'd14: v = 30'd65535;
      5'd15: v = 30'd32767;
      5'd16: v = 30'd16383;
      5'd17: v = 30'd8191;
      5'd18: v = 30'd4095;
      5'd19: v = 30'd2047;
      5'd20: v = 30'd1023;
      5'd21: v = 30'd511;
      5'd22: v = 30'd255;
      5'd23: v = 30'd127;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/dd_odo_mul.sv =====
`timescale 1ns / 1ps
module dd_odo_mul (
  input  logic                 clk_i,
  input  dd_odo_pkg::mul_op_t  a_i,
  input  dd_odo_pkg::mul_op_t  b_i,
  output dd_odo_pkg::prod_t    p_o
);
  import dd_odo_pkg::*;

  prod_t p_q;

  // register every product; the sequencer reads it in the cycle after
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

// ===== rtl/dd_odo_div.sv =====
`timescale 1ns / 1ps
module dd_odo_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [dd_odo_pkg::DIV_W-1:0]      dividend_i,
  input  logic [dd_odo_pkg::DVS_W-1:0]      divisor_i,
  output logic                              done_o,
  output logic [dd_odo_pkg::DIV_W-1:0]      quot_o
);
  import dd_odo_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// ===== rtl/dd_odo_cordic.sv =====
`timescale 1ns / 1ps
module dd_odo_cordic #(
  parameter int unsigned STEPS = dd_odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [32:0]  z_i,
  output logic                done_o,
  output logic signed [31:0]  cos_o,
  output logic signed [31:0]  sin_o
);
  import dd_odo_pkg::*;

  localparam int unsigned RUN_STEPS = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;

  logic signed [31:0]   x_q, y_q, xs, ys;
  logic signed [32:0]   z_q, at;
  logic [TAB_IDX_W-1:0] i_q;
  logic                 run_q, done_q, last;

  assign xs   = x_q >>> i_q;
  assign ys   = y_q >>> i_q;
  assign at   = $signed({3'b000, atan_entry(i_q)});
  assign last = i_q == TAB_IDX_W'(RUN_STEPS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= '0;
      end else if (run_q) begin
        i_q <= i_q + 1'b1;
        if (last) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // rotate towards zero residual angle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_K;
      y_q <= '0;
      z_q <= z_i;
    end else if (run_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;
endmodule

// ===== rtl/diff_drive_odometry_unit.sv =====
`timescale 1ns / 1ps
// Channel | Signals                                         | Direction
// --------+-------------------------------------------------+----------
// in      | in_valid_i/in_ready_o, left_angle_i, right_angle_i, stamp_us_i | to block
// out     | out_valid_o/out_ready_i, pos_x_o .. dt_zero_o   | from block
// cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i| to block
//
// Each request is processed in full before the next is accepted; the heading
// remainder may need its extra corrections. Three divisions by the
// one-bit-a-cycle divider dominate; with a zero time step the two speed
// divisions are skipped. Reset clears the pose, the previous sample and loads
// the default geometry. A finished result waits in the output register; the
// next request is taken meanwhile and stalls only at its own end if the old
// result is still held.
module diff_drive_odometry_unit #(
  parameter int unsigned CORDIC_STEPS = dd_odo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dd_odo_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [15:0]                          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [31:0]                   left_angle_i,
  input  logic signed [31:0]                   right_angle_i,
  input  logic [31:0]                          stamp_us_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [31:0]                   pos_x_o,
  output logic signed [31:0]                   pos_y_o,
  output logic signed [18:0]                   heading_out_o,
  output logic signed [17:0]                   quat_z_o,
  output logic signed [17:0]                   quat_w_o,
  output logic signed [31:0]                   linear_speed_o,
  output logic signed [31:0]                   angular_speed_o,
  output logic                                 dt_zero_o
);
  import dd_odo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MDS, S_MDTH, S_DTH_DIV, S_DTH_WAIT, S_MOD_MQ, S_MOD_MC,
    S_MOD_SUB, S_MOD_FIX, S_COR_RUN, S_COR_WAIT, S_MCC, S_MSS, S_MCS, S_MXI,
    S_MYI, S_YUPD, S_RLO, S_RHI, S_RDIV, S_RWAIT, S_DONE
  } state_e;

  state_e state_q;

  // geometry
  logic [15:0] radius_q, sep_q, r_q, s_q;

  // item state
  logic signed [31:0] prev_l_q, prev_r_q, x_acc_q, y_acc_q;
  logic [31:0]        prev_st_q, dt_q;
  logic signed [18:0] heading_q;
  logic signed [32:0] dl_q, dr_q, ds_q;
  logic signed [50:0] dth_q;
  logic signed [31:0] c_q, sn_q;
  logic signed [PROD_W-1:0] cc_q;
  logic signed [33:0] ch_q, sh_q;
  logic [47:0]        plo_q;
  logic [20:0]        modr_q;
  logic               neg_q, rsel_q;
  logic signed [31:0] lin_q, ang_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] o_x_q, o_y_q, o_lin_q, o_ang_q;
  logic signed [18:0] o_h_q;
  logic signed [17:0] o_qz_q, o_qw_q;
  logic               o_dtz_q;

  // shared units
  mul_op_t            mul_a, mul_b;
  prod_t              mul_p;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dvd, div_quot;
  logic [DVS_W-1:0]   div_dvs;
  logic               cor_start, cor_done;
  logic signed [31:0] cor_c, cor_s;

  // derived values
  logic signed [33:0] sum_w, diff_w;
  logic signed [51:0] hp, habs_s, num, mag_s;
  logic [51:0]        habs, mag;
  logic signed [PROD_W-1:0] pabs, inc_full;
  logic signed [38:0] acc_sum;
  logic signed [19:0] mod_m;
  logic [18:0]        rem19;
  logic signed [32:0] qw_r, qz_r;
  logic signed [31:0] sat_rate, sat_acc;
  logic signed [18:0] qw_t, qz_t;
  logic signed [17:0] qw_c, qz_c;
  logic               accept_in;

  assign accept_in = in_valid_i && in_ready_o;
  assign in_ready_o  = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;

  assign sum_w  = 34'(dr_q) + 34'(dl_q);
  assign diff_w = 34'(dr_q) - 34'(dl_q);
  assign hp     = 52'(heading_q) + 52'(dth_q) + 52'(PI_Q);
  assign habs_s = hp[51] ? -hp : hp;
  assign habs   = habs_s;
  assign num    = rsel_q ? 52'(dth_q) : 52'(ds_q);
  assign mag_s  = num[51] ? -num : num;
  assign mag    = mag_s;
  assign pabs   = mul_p[PROD_W-1] ? -mul_p : mul_p;

  // heading remainder: the reciprocal estimate of the quotient is at most
  // two short, so the partial remainder below is under three turns
  assign rem19  = modr_q[18:0];
  assign mod_m  = (neg_q && (rem19 != '0)) ? TWO_PI_Q - 20'($signed({1'b0, rem19}))
                                            : 20'($signed({1'b0, rem19}));

  // position increment rounded, then saturating accumulate
  assign inc_full = (mul_p + (PROD_W'(1) <<< 29)) >>> 30;
  assign acc_sum  = 39'((state_q == S_MYI) ? x_acc_q : y_acc_q) +
                    39'($signed(inc_full[37:0]));
  always_comb begin
    if (acc_sum > 39'sd2147483647)       sat_acc = 32'sh7fffffff;
    else if (acc_sum < -39'sd2147483648) sat_acc = 32'sh80000000;
    else                                 sat_acc = acc_sum[31:0];
  end

  // quotient magnitude back to a signed, saturated speed
  always_comb begin
    if (!neg_q) begin
      sat_rate = (|div_quot[DIV_W-1:31]) ? 32'sh7fffffff : $signed(div_quot[31:0]);
    end else if ((|div_quot[DIV_W-1:32]) || (div_quot[31] && (|div_quot[30:0]))) begin
      sat_rate = 32'sh80000000;
    end else begin
      sat_rate = -$signed(div_quot[31:0]);
    end
  end

  // quaternion rounding and clamp
  assign qw_r = (33'(c_q) + 33'sd8192) >>> 14;
  assign qz_r = (33'(sn_q) + 33'sd8192) >>> 14;
  assign qw_t = qw_r[18:0];
  assign qz_t = qz_r[18:0];
  assign qw_c = (qw_t > 19'sd65536) ? 18'sd65536 :
                (qw_t < -19'sd65536) ? -18'sd65536 : qw_t[17:0];
  assign qz_c = (qz_t > 19'sd65536) ? 18'sd65536 :
                (qz_t < -19'sd65536) ? -18'sd65536 : qz_t[17:0];

  // multiplier operand select by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MDS:  begin mul_a = MUL_W'({1'b0, r_q}); mul_b = sum_w;  end
      S_MDTH: begin mul_a = MUL_W'({1'b0, r_q}); mul_b = diff_w; end
      S_MOD_MQ: begin
        mul_a = MUL_W'({1'b0, habs[49:18]});
        mul_b = TWO_PI_RECIP;
      end
      S_MOD_MC: begin
        mul_a = MUL_W'({1'b0, mul_p[64:33]});
        mul_b = MUL_W'(TWO_PI_Q);
      end
      S_MCC:  begin mul_a = MUL_W'(c_q);  mul_b = MUL_W'(c_q);  end
      S_MSS:  begin mul_a = MUL_W'(sn_q); mul_b = MUL_W'(sn_q); end
      S_MCS:  begin mul_a = MUL_W'(c_q);  mul_b = MUL_W'(sn_q); end
      S_MXI:  begin mul_a = MUL_W'(ds_q); mul_b = ch_q; end
      S_MYI:  begin mul_a = MUL_W'(ds_q); mul_b = sh_q; end
      S_RLO:  begin mul_a = MUL_W'({1'b0, mag[25:0]});  mul_b = MUL_W'({1'b0, US_PER_S}); end
      S_RHI:  begin mul_a = MUL_W'({1'b0, mag[51:26]}); mul_b = MUL_W'({1'b0, US_PER_S}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider requests
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_q)
      S_DTH_DIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_W'(pabs[49:0]);
        div_dvs   = DVS_W'(s_q);
      end
      S_RDIV: begin
        div_start = 1'b1;
        div_dvd   = (DIV_W'(mul_p[47:0]) << 26) + DIV_W'(plo_q);
        div_dvs   = dt_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  assign cor_start = state_q == S_COR_RUN;

  dd_odo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  dd_odo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  dd_odo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .z_i     (33'(heading_q) <<< 13),
    .done_o  (cor_done),
    .cos_o   (cor_c),
    .sin_o   (cor_s)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      sep_q    <= SEP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RADIUS: radius_q <= cfg_data_i;
        REG_SEP:    sep_q    <= cfg_data_i;
        default:    radius_q <= radius_q;
      endcase
    end
  end

  // sequencer: state, pose and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      prev_st_q   <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
      rsel_q      <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      // drop a taken result unless a new one replaces it this cycle
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept_in) begin
            dl_q      <= 33'(left_angle_i) - 33'(prev_l_q);
            dr_q      <= 33'(right_angle_i) - 33'(prev_r_q);
            dt_q      <= stamp_us_i - prev_st_q;
            prev_l_q  <= left_angle_i;
            prev_r_q  <= right_angle_i;
            prev_st_q <= stamp_us_i;
            r_q       <= radius_q;
            s_q       <= (sep_q == '0) ? 16'd1 : sep_q;
            lin_q     <= '0;
            ang_q     <= '0;
            state_q   <= S_MDS;
          end
        end
        S_MDS:  state_q <= S_MDTH;
        S_MDTH: begin
          ds_q    <= 33'((mul_p + PROD_W'(65536)) >>> 17);
          state_q <= S_DTH_DIV;
        end
        S_DTH_DIV: begin
          neg_q   <= mul_p[PROD_W-1];
          state_q <= S_DTH_WAIT;
        end
        S_DTH_WAIT: begin
          if (div_done) begin
            dth_q   <= neg_q ? -$signed(div_quot[50:0]) : $signed(div_quot[50:0]);
            state_q <= S_MOD_MQ;
          end
        end
        S_MOD_MQ: begin
          neg_q   <= hp[51];
          state_q <= S_MOD_MC;
        end
        S_MOD_MC: state_q <= S_MOD_SUB;
        S_MOD_SUB: begin
          // the remainder is small, so its low bits are exact
          modr_q  <= habs[20:0] - mul_p[20:0];
          state_q <= S_MOD_FIX;
        end
        S_MOD_FIX: begin
          if (modr_q >= 21'(TWO_PI_Q)) begin
            modr_q <= modr_q - 21'(TWO_PI_Q);
          end else begin
            heading_q <= 19'(mod_m - PI_Q);
            state_q   <= S_COR_RUN;
          end
        end
        S_COR_RUN:  state_q <= S_COR_WAIT;
        S_COR_WAIT: begin
          if (cor_done) begin
            c_q     <= cor_c;
            sn_q    <= cor_s;
            state_q <= S_MCC;
          end
        end
        S_MCC: state_q <= S_MSS;
        S_MSS: begin
          cc_q    <= mul_p;
          state_q <= S_MCS;
        end
        S_MCS: begin
          ch_q    <= 34'((cc_q - mul_p) >>> 30);
          state_q <= S_MXI;
        end
        S_MXI: begin
          sh_q    <= 34'(mul_p >>> 29);
          state_q <= S_MYI;
        end
        S_MYI: begin
          x_acc_q <= sat_acc;
          state_q <= S_YUPD;
        end
        S_YUPD: begin
          y_acc_q <= sat_acc;
          rsel_q  <= 1'b0;
          state_q <= (dt_q == '0) ? S_DONE : S_RLO;
        end
        S_RLO: state_q <= S_RHI;
        S_RHI: begin
          plo_q   <= mul_p[47:0];
          neg_q   <= num[51];
          state_q <= S_RDIV;
        end
        S_RDIV: state_q <= S_RWAIT;
        S_RWAIT: begin
          if (div_done) begin
            if (!rsel_q) begin
              lin_q   <= sat_rate;
              rsel_q  <= 1'b1;
              state_q <= S_RLO;
            end else begin
              ang_q   <= sat_rate;
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // hold until the previous result has been taken
          if (!out_valid_q || out_ready_i) begin
            o_x_q       <= x_acc_q;
            o_y_q       <= y_acc_q;
            o_h_q       <= heading_q;
            o_qz_q      <= qz_c;
            o_qw_q      <= qw_c;
            o_lin_q     <= lin_q;
            o_ang_q     <= ang_q;
            o_dtz_q     <= dt_q == '0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = o_x_q;
  assign pos_y_o         = o_y_q;
  assign heading_out_o   = o_h_q;
  assign quat_z_o        = o_qz_q;
  assign quat_w_o        = o_qw_q;
  assign linear_speed_o  = o_lin_q;
  assign angular_speed_o = o_ang_q;
  assign dt_zero_o       = o_dtz_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> !in_ready_o)
    else $error("request taken while busy");

  a_div_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DTH_WAIT || state_q == S_RWAIT))
    else $error("divider finished outside a wait step");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_out_o >= -19'sd205887 && heading_out_o <= 19'sd205887))
    else $error("heading out of range");

  a_dt_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dt_zero_o) |-> (linear_speed_o == '0 && angular_speed_o == '0))
    else $error("speed reported with zero time step");
`endif
endmodule
